FILE: hw/rtl/marching_squares_contour_unit_defines.svh
// assertion macros shared by the contour unit rtl
// expects clk and rst_n in the scope of every use
`ifndef MARCHING_SQUARES_CONTOUR_UNIT_DEFINES_SVH
`define MARCHING_SQUARES_CONTOUR_UNIT_DEFINES_SVH

// property checked on every rising edge outside reset
`define MSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// signal holds its value in the cycle after a condition
`define MSC_ASSERT_HOLD(lbl, cond, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

FILE: hw/rtl/msc_pkg.sv
// shared types, constants and case tables of the contour unit
// no dependencies
package msc_pkg;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 10;
  localparam int ROWS_REG_BITS  = 9;
  localparam int COL_BITS       = 10;
  localparam int OUT_ROW_BITS   = 8;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_CELL_ROWS    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CELL_COLUMNS = 2'd1;

  localparam logic [ROWS_REG_BITS-1:0] CELL_ROWS_RESET    = 9'd60;
  localparam logic [COL_BITS-1:0]      CELL_COLUMNS_RESET = 10'd80;

  typedef enum logic [1:0] {
    EDGE_TOP    = 2'd0,
    EDGE_BOTTOM = 2'd1,
    EDGE_LEFT   = 2'd2,
    EDGE_RIGHT  = 2'd3
  } edge_t;

  // controller to datapath
  typedef struct packed {
    logic accept;     // input transfer this cycle
    logic load;       // store read data valid, write back the new sample
    logic div_start;  // launch a crossing on the divider
    logic pt_store;   // divider result goes into the output point
    logic seg;        // segment number within the cell
    logic pt;         // 0 start point, 1 end point
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] seg_count;
    logic       div_done;
  } dp_status_t;

  function automatic logic [1:0] seg_count_of(input logic [3:0] idx);
    logic [1:0] n;
    unique case (idx)
      4'd0, 4'd15: n = 2'd0;
      4'd6, 4'd9:  n = 2'd2;
      default:     n = 2'd1;
    endcase
    return n;
  endfunction

  // start/end edges of the first and second segment of a cell index
  function automatic edge_t seg_edge(input logic [3:0] idx, input logic seg, input logic pt);
    edge_t [0:3] tab;
    unique case (idx)
      4'd1:    tab = '{EDGE_TOP, EDGE_LEFT, EDGE_TOP, EDGE_TOP};
      4'd2:    tab = '{EDGE_RIGHT, EDGE_TOP, EDGE_TOP, EDGE_TOP};
      4'd3:    tab = '{EDGE_LEFT, EDGE_RIGHT, EDGE_TOP, EDGE_TOP};
      4'd4:    tab = '{EDGE_LEFT, EDGE_BOTTOM, EDGE_TOP, EDGE_TOP};
      4'd5:    tab = '{EDGE_TOP, EDGE_BOTTOM, EDGE_TOP, EDGE_TOP};
      4'd6:    tab = '{EDGE_TOP, EDGE_RIGHT, EDGE_BOTTOM, EDGE_LEFT};
      4'd7:    tab = '{EDGE_BOTTOM, EDGE_RIGHT, EDGE_TOP, EDGE_TOP};
      4'd8:    tab = '{EDGE_BOTTOM, EDGE_RIGHT, EDGE_TOP, EDGE_TOP};
      4'd9:    tab = '{EDGE_LEFT, EDGE_TOP, EDGE_RIGHT, EDGE_BOTTOM};
      4'd10:   tab = '{EDGE_TOP, EDGE_BOTTOM, EDGE_TOP, EDGE_TOP};
      4'd11:   tab = '{EDGE_LEFT, EDGE_BOTTOM, EDGE_TOP, EDGE_TOP};
      4'd12:   tab = '{EDGE_LEFT, EDGE_RIGHT, EDGE_TOP, EDGE_TOP};
      4'd13:   tab = '{EDGE_TOP, EDGE_RIGHT, EDGE_TOP, EDGE_TOP};
      4'd14:   tab = '{EDGE_TOP, EDGE_LEFT, EDGE_TOP, EDGE_TOP};
      default: tab = '{EDGE_TOP, EDGE_TOP, EDGE_TOP, EDGE_TOP};
    endcase
    return tab[{seg, pt}];
  endfunction

endpackage

FILE: hw/rtl/msc_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module msc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 257
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/msc_divider.sv
// radix-2 restoring divider for edge crossings fa / (fa - fb), clamped
// depends on marching_squares_contour_unit_defines.svh
`include "marching_squares_contour_unit_defines.svh"

module msc_divider #(
  parameter int SAMPLE_BITS   = 16,
  parameter int FRACTION_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [SAMPLE_BITS-1:0] fa,
  input  logic signed [SAMPLE_BITS-1:0] fb,
  output logic                          done,
  output logic [FRACTION_BITS:0]        result
);

  localparam int SB = SAMPLE_BITS;
  localparam int F  = FRACTION_BITS;
  localparam int CW = $clog2(F + 1);
  localparam logic [F:0] UNIT = {1'b1, {F{1'b0}}};
  localparam logic [F:0] MID  = {2'b01, {(F - 1){1'b0}}};

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [SB-1:0] rem_r;
  logic [SB-1:0] ad_r;
  logic [F-1:0]  q_r;
  logic [F:0]    result_r;

  logic signed [SB:0] fa_ext;
  logic signed [SB:0] den;
  logic [SB:0]        fa_abs;
  logic [SB:0]        den_abs;
  logic [SB-1:0]      an;
  logic [SB-1:0]      ad;
  logic [SB:0]        trial;
  logic               ge;
  logic [SB-1:0]      rem_nxt;
  logic [F-1:0]       q_nxt;

  always_comb begin
    fa_ext  = {fa[SB-1], fa};
    den     = fa_ext - {fb[SB-1], fb};
    fa_abs  = fa_ext[SB] ? -fa_ext : fa_ext;
    den_abs = den[SB] ? -den : den;
    an      = fa_abs[SB-1:0];
    ad      = den_abs[SB-1:0];
    // one quotient bit per cycle
    trial   = {rem_r, 1'b0};
    ge      = trial >= {1'b0, ad_r};
    rem_nxt = ge ? SB'(trial - {1'b0, ad_r}) : trial[SB-1:0];
    q_nxt   = {q_r[F-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        priority if (den == '0) begin
          result_r <= MID;
          done_r   <= 1'b1;
        end else if ((fa_ext[SB] != den[SB]) || (fa == '0)) begin
          result_r <= '0;
          done_r   <= 1'b1;
        end else if (an >= ad) begin
          result_r <= UNIT;
          done_r   <= 1'b1;
        end else begin
          rem_r  <= an;
          ad_r   <= ad;
          q_r    <= '0;
          cnt_r  <= CW'(F);
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        q_r   <= q_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r   <= 1'b0;
          done_r   <= 1'b1;
          result_r <= {1'b0, q_nxt};
        end
      end
    end
  end

  assign done   = done_r;
  assign result = result_r;

  `MSC_ASSERT(a_div_start_idle, start |-> !busy_r, "divider started while busy")
  `MSC_ASSERT(a_div_progress, busy_r |=> (busy_r || done_r), "divider stopped without result")
  `MSC_ASSERT(a_div_range, done_r |-> (result_r <= UNIT), "crossing beyond cell edge")

endmodule

FILE: hw/rtl/msc_datapath.sv
// datapath: config registers, grid position, line store, cell corners,
// crossing divider and result registers; depends on msc_pkg, msc_ram, msc_divider
module msc_datapath #(
  parameter int MAX_ROWS      = 256,
  parameter int SAMPLE_BITS   = 16,
  parameter int FRACTION_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  msc_pkg::ctrl_cmd_t                    cmd,
  output msc_pkg::dp_status_t                   status,
  input  logic                                  cfg_wr,
  input  logic [msc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [msc_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  input  logic signed [SAMPLE_BITS-1:0]         in_sample,
  input  logic                                  in_frame_start,
  output logic [msc_pkg::COL_BITS-1:0]          out_cell_column,
  output logic [msc_pkg::OUT_ROW_BITS-1:0]      out_cell_row,
  output logic [FRACTION_BITS:0]                out_start_x,
  output logic [FRACTION_BITS:0]                out_start_y,
  output logic [FRACTION_BITS:0]                out_end_x,
  output logic [FRACTION_BITS:0]                out_end_y,
  output logic                                  out_last
);
  import msc_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int F  = FRACTION_BITS;
  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam logic [F:0] UNIT = {1'b1, {F{1'b0}}};

  logic [ROWS_REG_BITS-1:0] cfg_rows_r;
  logic [COL_BITS-1:0]      cfg_cols_r;

  logic [RW-1:0]       row_r;
  logic [COL_BITS-1:0] col_r;
  logic [RW-1:0]       cur_row_r;
  logic [COL_BITS-1:0] cur_col_r;
  logic                closed_r;

  logic signed [SB-1:0] old_above_r;
  logic signed [SB-1:0] new_above_r;
  logic signed [SB-1:0] tl_r;
  logic signed [SB-1:0] tr_r;
  logic signed [SB-1:0] br_r;
  logic signed [SB-1:0] bl;
  edge_t                edge_r;

  logic [COL_BITS-1:0]     out_col_r;
  logic [OUT_ROW_BITS-1:0] out_row_r;
  logic [F:0]              sx_r;
  logic [F:0]              sy_r;
  logic [F:0]              ex_r;
  logic [F:0]              ey_r;
  logic                    last_r;

  // position arithmetic for the sample being taken
  logic [RW-1:0]       rows_eff;
  logic [COL_BITS-1:0] cols_eff;
  logic [RW-1:0]       rp0;
  logic [RW-1:0]       rp1;
  logic [COL_BITS:0]   cp0;
  logic [COL_BITS:0]   cp1;
  logic [COL_BITS:0]   cp2;
  logic [COL_BITS:0]   cp3;
  logic [RW:0]         rp_inc;
  logic [RW-1:0]       row_nxt;
  logic [COL_BITS-1:0] col_nxt;

  logic [3:0]           idx;
  edge_t                edge_sel;
  logic signed [SB-1:0] div_fa;
  logic signed [SB-1:0] div_fb;
  logic                 div_done;
  logic [F:0]           div_q;
  logic [F:0]           pt_x;
  logic [F:0]           pt_y;
  logic [RW-1:0]        row_m1;
  logic [SB-1:0]        store_rd;

  always_comb begin
    priority if (cfg_rows_r == '0) begin
      rows_eff = RW'(1);
    end else if (32'(cfg_rows_r) > MAX_ROWS) begin
      rows_eff = RW'(MAX_ROWS);
    end else begin
      rows_eff = RW'(cfg_rows_r);
    end
    cols_eff = (cfg_cols_r == '0) ? COL_BITS'(1) : cfg_cols_r;

    rp0 = in_frame_start ? '0 : row_r;
    cp0 = in_frame_start ? '0 : {1'b0, col_r};
    // row count lowered since the last sample
    if (rp0 > rows_eff) begin
      rp1 = '0;
      cp1 = cp0 + 1'b1;
    end else begin
      rp1 = rp0;
      cp1 = cp0;
    end
    cp2 = (cp1 > {1'b0, cols_eff}) ? '0 : cp1;

    // advance past this sample, wrapping column and frame
    rp_inc = {1'b0, rp1} + 1'b1;
    cp3    = cp2 + 1'b1;
    if (rp_inc > {1'b0, rows_eff}) begin
      row_nxt = '0;
      col_nxt = (cp3 > {1'b0, cols_eff}) ? '0 : cp3[COL_BITS-1:0];
    end else begin
      row_nxt = rp_inc[RW-1:0];
      col_nxt = cp2[COL_BITS-1:0];
    end
  end

  msc_ram #(
    .WIDTH(SB),
    .DEPTH(MAX_ROWS + 1)
  ) u_column_store (
    .clk    (clk),
    .wr_en  (cmd.load),
    .wr_addr(cur_row_r),
    .wr_data(br_r),
    .rd_en  (cmd.accept),
    .rd_addr(rp1),
    .rd_data(store_rd)
  );

  // bottom-left corner comes straight from the store read register
  assign bl  = store_rd;
  assign idx = {br_r[SB-1], bl[SB-1], tr_r[SB-1], tl_r[SB-1]};

  always_comb begin
    edge_sel = seg_edge(idx, cmd.seg, cmd.pt);
    unique case (edge_sel)
      EDGE_TOP: begin
        div_fa = tl_r;
        div_fb = tr_r;
      end
      EDGE_BOTTOM: begin
        div_fa = bl;
        div_fb = br_r;
      end
      EDGE_LEFT: begin
        div_fa = tl_r;
        div_fb = bl;
      end
      default: begin
        div_fa = tr_r;
        div_fb = br_r;
      end
    endcase
  end

  msc_divider #(
    .SAMPLE_BITS  (SB),
    .FRACTION_BITS(F)
  ) u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .fa    (div_fa),
    .fb    (div_fb),
    .done  (div_done),
    .result(div_q)
  );

  always_comb begin
    unique case (edge_r)
      EDGE_TOP: begin
        pt_x = div_q;
        pt_y = '0;
      end
      EDGE_BOTTOM: begin
        pt_x = div_q;
        pt_y = UNIT;
      end
      EDGE_LEFT: begin
        pt_x = '0;
        pt_y = div_q;
      end
      default: begin
        pt_x = UNIT;
        pt_y = div_q;
      end
    endcase
    row_m1 = cur_row_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_rows_r  <= CELL_ROWS_RESET;
      cfg_cols_r  <= CELL_COLUMNS_RESET;
      row_r       <= '0;
      col_r       <= '0;
      closed_r    <= 1'b0;
      old_above_r <= '0;
      new_above_r <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_index)
          CFG_CELL_ROWS:    cfg_rows_r <= cfg_data[ROWS_REG_BITS-1:0];
          CFG_CELL_COLUMNS: cfg_cols_r <= cfg_data[COL_BITS-1:0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        row_r       <= row_nxt;
        col_r       <= col_nxt;
        closed_r    <= (rp1 != '0) && (cp2 != '0);
        new_above_r <= in_sample;
      end
      if (cmd.load) begin
        old_above_r <= bl;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_row_r <= rp1;
      cur_col_r <= cp2[COL_BITS-1:0];
      tl_r      <= old_above_r;
      tr_r      <= new_above_r;
      br_r      <= in_sample;
    end
    if (cmd.div_start) begin
      edge_r <= edge_sel;
    end
    if (cmd.pt_store) begin
      out_col_r <= cur_col_r - 1'b1;
      out_row_r <= OUT_ROW_BITS'(row_m1);
      last_r    <= cmd.seg || (status.seg_count == 2'd1);
      if (cmd.pt) begin
        ex_r <= pt_x;
        ey_r <= pt_y;
      end else begin
        sx_r <= pt_x;
        sy_r <= pt_y;
      end
    end
  end

  assign status.seg_count = closed_r ? seg_count_of(idx) : 2'd0;
  assign status.div_done  = div_done;

  assign out_cell_column = out_col_r;
  assign out_cell_row    = out_row_r;
  assign out_start_x     = sx_r;
  assign out_start_y     = sy_r;
  assign out_end_x       = ex_r;
  assign out_end_y       = ey_r;
  assign out_last        = last_r;

endmodule

FILE: hw/rtl/msc_controller.sv
// controller: sequences load, crossings and result transfers of one sample
// depends on msc_pkg and marching_squares_contour_unit_defines.svh
`include "marching_squares_contour_unit_defines.svh"

module msc_controller (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  msc_pkg::dp_status_t status,
  output msc_pkg::ctrl_cmd_t  cmd
);
  import msc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_DIV_GO,
    S_DIV_WAIT,
    S_EMIT
  } state_t;

  state_t state_r;
  logic   seg_r;
  logic   pt_r;
  logic   out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seg_r       <= 1'b0;
      pt_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          seg_r <= 1'b0;
          pt_r  <= 1'b0;
          state_r <= (status.seg_count == 2'd0) ? S_IDLE : S_DIV_GO;
        end
        S_DIV_GO: begin
          state_r <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (status.div_done) begin
            if (pt_r) begin
              out_valid_r <= 1'b1;
              state_r     <= S_EMIT;
            end else begin
              pt_r    <= 1'b1;
              state_r <= S_DIV_GO;
            end
          end
        end
        S_EMIT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            if (!seg_r && (status.seg_count == 2'd2)) begin
              seg_r   <= 1'b1;
              pt_r    <= 1'b0;
              state_r <= S_DIV_GO;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.accept    = (state_r == S_IDLE) && in_valid;
    cmd.load      = (state_r == S_LOAD);
    cmd.div_start = (state_r == S_DIV_GO);
    cmd.pt_store  = (state_r == S_DIV_WAIT) && status.div_done;
    cmd.seg       = seg_r;
    cmd.pt        = pt_r;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  `MSC_ASSERT(a_done_when_waiting, status.div_done |-> (state_r == S_DIV_WAIT),
    "crossing finished outside wait state")
  `MSC_ASSERT(a_second_only_saddle, (out_valid_r && seg_r) |-> (status.seg_count == 2'd2),
    "second segment from a non-saddle cell")
  `MSC_ASSERT(a_empty_cell_skips, (state_r == S_LOAD && status.seg_count == 2'd0) |=>
    (state_r == S_IDLE && !out_valid_r), "empty cell produced work")

endmodule

FILE: hw/rtl/marching_squares_contour_unit.sv
// top level of the marching-squares contour unit
// depends on msc_pkg, msc_controller, msc_datapath (msc_ram, msc_divider)
//
// usage:
//   in_*   one grid sample per transfer, column by column, top row first;
//          in_frame_start restarts the grid at column 0, row 0
//   out_*  one line segment per transfer, out_last marks the final segment
//          caused by a sample; out_cell_column/out_cell_row locate the cell
//   cfg_*  register writes (index 0 cell_rows, 1 cell_columns); cfg_ready is
//          always high, write only while the unit is idle
// sequencing:
//   a sample that closes no cell, or an empty cell, goes from load back to idle
//   each segment: 2 crossings on the shared radix-2 divider
//   (a degenerate crossing skips the divide loop), then the output register
//   holds the segment until it transfers; one sample is worked on at a time
// reset: cell_rows 60, cell_columns 80, position column 0 row 0; the line
//   store is not cleared, the first column reads it but closes no cell
// stall: a stalled result holds in the output register and the unit takes
//   no new sample until every result of the current one has transferred
module marching_squares_contour_unit #(
  parameter int MAX_ROWS      = 256,
  parameter int SAMPLE_BITS   = 16,
  parameter int FRACTION_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // sample channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [SAMPLE_BITS-1:0]      in_sample,
  input  logic                               in_frame_start,
  // segment channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [msc_pkg::COL_BITS-1:0]       out_cell_column,
  output logic [msc_pkg::OUT_ROW_BITS-1:0]   out_cell_row,
  output logic [FRACTION_BITS:0]             out_start_x,
  output logic [FRACTION_BITS:0]             out_start_y,
  output logic [FRACTION_BITS:0]             out_end_x,
  output logic [FRACTION_BITS:0]             out_end_y,
  output logic                               out_last,
  // register writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [msc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [msc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import msc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // registers are plain flops, a write never waits
  assign cfg_ready = 1'b1;

  msc_controller u_controller (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // position tracking, line store, corners, divider and result payload
  msc_datapath #(
    .MAX_ROWS     (MAX_ROWS),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .cfg_wr         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_sample      (in_sample),
    .in_frame_start (in_frame_start),
    .out_cell_column(out_cell_column),
    .out_cell_row   (out_cell_row),
    .out_start_x    (out_start_x),
    .out_start_y    (out_start_y),
    .out_end_x      (out_end_x),
    .out_end_y      (out_end_y),
    .out_last       (out_last)
  );

endmodule
